>>> rtl/pdb_pkg.sv
// Shared constants of the point depth buffer: commands, status codes, registers, sizes.
`default_nettype none
package pdb_pkg;
   localparam int CELLS_X_DEF    = 256;
   localparam int CELLS_Y_DEF    = 256;
   localparam int INDEX_BITS_DEF = 24;

   localparam int DEPTH_W = 26;
   localparam int SIDX_W  = 24;

   localparam logic [1:0] CMD_INSERT  = 2'd0;
   localparam logic [1:0] CMD_READ    = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;
   localparam logic [1:0] CMD_IGNORED = 2'd3;

   localparam logic [2:0] ST_STORED  = 3'd0;
   localparam logic [2:0] ST_FARTHER = 3'd1;
   localparam logic [2:0] ST_OUTSIDE = 3'd2;
   localparam logic [2:0] ST_RANGE   = 3'd3;
   localparam logic [2:0] ST_HIT     = 3'd4;
   localparam logic [2:0] ST_EMPTY   = 3'd5;
   localparam logic [2:0] ST_CLEARED = 3'd6;

   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_SUBDIV = 3'd2;
   localparam logic [2:0] REG_CAM_X  = 3'd3;
   localparam logic [2:0] REG_CAM_Y  = 3'd4;
   localparam logic [2:0] REG_CAM_Z  = 3'd5;
endpackage
`default_nettype wire

>>> rtl/pdb_cell_mem.sv
// Cell memory: one write port and one read port with registered read data.
`default_nettype none
module pdb_cell_mem
   import pdb_pkg::*;
#(
   parameter int DEPTH = CELLS_X_DEF * CELLS_Y_DEF,
   parameter int WIDTH = 1 + DEPTH_W + INDEX_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> rtl/pdb_depth_unit.sv
// Depth unit: squared distance with one shared multiplier, then a bit-serial square root.
`default_nettype none
module pdb_depth_unit
   import pdb_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic signed [23:0]        world_x,
   input  wire logic signed [23:0]        world_y,
   input  wire logic signed [23:0]        world_z,
   input  wire logic signed [23:0]        cam_x,
   input  wire logic signed [23:0]        cam_y,
   input  wire logic signed [23:0]        cam_z,
   output logic                           done,
   output logic [DEPTH_W-1:0]             depth
);
   typedef enum logic [1:0] {D_IDLE, D_SQ, D_ROOT} dstate_type;

   dstate_type  state_ff;
   logic [1:0]  cnt_ff;
   logic [4:0]  iter_ff;
   logic [24:0] mag_x_ff, mag_y_ff, mag_z_ff;
   logic [49:0] prod_ff;
   logic [49:0] sum_ff;
   logic [25:0] rem_ff;
   logic [24:0] root_ff;
   logic        done_ff;

   logic signed [24:0] dx, dy, dz;
   logic [24:0] sel;
   logic [27:0] rem_t, trial;

   assign dx = {world_x[23], world_x} - {cam_x[23], cam_x};
   assign dy = {world_y[23], world_y} - {cam_y[23], cam_y};
   assign dz = {world_z[23], world_z} - {cam_z[23], cam_z};

   always_comb begin
      case (cnt_ff)
         2'd0:    sel = mag_x_ff;
         2'd1:    sel = mag_y_ff;
         default: sel = mag_z_ff;
      endcase
   end

   assign rem_t = {rem_ff, sum_ff[49:48]};
   assign trial = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  mag_x_ff <= dx[24] ? 25'(-dx) : 25'(dx);
                  mag_y_ff <= dy[24] ? 25'(-dy) : 25'(dy);
                  mag_z_ff <= dz[24] ? 25'(-dz) : 25'(dz);
                  cnt_ff   <= 2'd0;
                  sum_ff   <= '0;
                  state_ff <= D_SQ;
               end
            end
            D_SQ: begin
               // The product of one step is added in the next.
               prod_ff <= sel * sel;
               if (cnt_ff != 2'd0) begin
                  sum_ff <= sum_ff + prod_ff;
               end
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  iter_ff  <= '0;
                  state_ff <= D_ROOT;
               end
            end
            D_ROOT: begin
               if (rem_t >= trial) begin
                  rem_ff  <= 26'(rem_t - trial);
                  root_ff <= {root_ff[23:0], 1'b1};
               end else begin
                  rem_ff  <= 26'(rem_t);
                  root_ff <= {root_ff[23:0], 1'b0};
               end
               sum_ff  <= {sum_ff[47:0], 2'b00};
               iter_ff <= iter_ff + 5'd1;
               if (iter_ff == 5'd24) begin
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done  = done_ff;
   assign depth = {1'b0, root_ff};
endmodule
`default_nettype wire

>>> rtl/point_depth_buffer.sv
// Top level of the point depth buffer: command control, registers and cell memory.
// An insert runs four shared-multiplier steps, then the 25-step serial square root; one
// beyond the cells writes no cell, an outside point skips the depth, a read waits on memory.
// A clear sweeps all CELLS_X*CELLS_Y entries of the cell memory one entry a cycle.
// Reset starts the same sweep; busy stays high until the sweep ends.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none
module point_depth_buffer
   import pdb_pkg::*;
#(
   parameter int CELLS_X    = CELLS_X_DEF,
   parameter int CELLS_Y    = CELLS_Y_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [1:0]          req_cmd,
   input  wire logic signed [20:0]  req_image_x,
   input  wire logic signed [20:0]  req_image_y,
   input  wire logic signed [23:0]  req_world_x,
   input  wire logic signed [23:0]  req_world_y,
   input  wire logic signed [23:0]  req_world_z,
   input  wire logic [23:0]         req_source_index,
   input  wire logic [7:0]          req_read_cell_x,
   input  wire logic [7:0]          req_read_cell_y,
   output logic                     rsp_valid,
   output logic [2:0]               rsp_status,
   output logic [DEPTH_W-1:0]       rsp_depth,
   output logic [SIDX_W-1:0]        rsp_stored_index,
   output logic [DEPTH_W-1:0]       rsp_min_depth,
   output logic [DEPTH_W-1:0]       rsp_max_depth,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [4:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   localparam int NCELLS = CELLS_X * CELLS_Y;
   localparam int AW     = $clog2(NCELLS);
   localparam int MW     = 1 + DEPTH_W + INDEX_BITS;

   typedef enum logic [2:0] {S_IDLE, S_DEPTH, S_UPD, S_RDW, S_RESP, S_CLEAR} state_type;

   state_type              state_ff;
   logic [AW-1:0]          addr_ff;
   logic [AW-1:0]          clr_ff;
   logic                   clr_rsp_ff;
   logic                   range_ff;
   logic [INDEX_BITS-1:0]  sidx_ff;
   logic [DEPTH_W-1:0]     least_ff, greatest_ff;
   logic                   rsp_valid_ff;
   logic [2:0]             rsp_status_ff;
   logic [DEPTH_W-1:0]     rsp_depth_ff;
   logic [SIDX_W-1:0]      rsp_sidx_ff;
   logic [11:0]            width_ff, height_ff;
   logic [4:0]             subdiv_ff;
   logic [23:0]            cam_x_ff, cam_y_ff, cam_z_ff;

   logic                   accept, csr_write;
   logic [21:0]            ix22, iy22, xlim, ylim;
   logic                   in_border;
   logic [4:0]             scale;
   logic [24:0]            prod_x, prod_y;
   logic [16:0]            cell_x, cell_y;
   logic                   cell_ok, read_ok;
   logic [AW-1:0]          ins_addr, rd_addr_cmd;
   logic                   du_done;
   logic [DEPTH_W-1:0]     du_depth;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [MW-1:0]          mem_wdata, mem_rdata;
   logic                   ent_valid;
   logic [DEPTH_W-1:0]     ent_depth;
   logic [INDEX_BITS-1:0]  ent_index;
   logic                   take;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   // Border test in 12.8 fixed point: 1.0 <= pos < size - 1.
   assign ix22   = {req_image_x[20], req_image_x};
   assign iy22   = {req_image_y[20], req_image_y};
   assign xlim   = {2'b00, width_ff, 8'h00} - 22'd256;
   assign ylim   = {2'b00, height_ff, 8'h00} - 22'd256;
   assign in_border = ($signed(ix22) >= 22'sd256) && ($signed(ix22) < $signed(xlim)) &&
                      ($signed(iy22) >= 22'sd256) && ($signed(iy22) < $signed(ylim));

   assign scale   = (subdiv_ff == 5'd0) ? 5'd1 : subdiv_ff;
   assign prod_x  = req_image_x[19:0] * scale;
   assign prod_y  = req_image_y[19:0] * scale;
   assign cell_x  = prod_x[24:8];
   assign cell_y  = prod_y[24:8];
   assign cell_ok = (32'(cell_x) < 32'(CELLS_X)) && (32'(cell_y) < 32'(CELLS_Y));
   assign ins_addr = AW'(32'(cell_y) * 32'(CELLS_X) + 32'(cell_x));

   assign read_ok = (32'(req_read_cell_x) < 32'(CELLS_X)) &&
                    (32'(req_read_cell_y) < 32'(CELLS_Y));
   assign rd_addr_cmd = AW'(32'(req_read_cell_y) * 32'(CELLS_X) + 32'(req_read_cell_x));

   assign ent_valid = mem_rdata[MW-1];
   assign ent_depth = mem_rdata[MW-2 -: DEPTH_W];
   assign ent_index = mem_rdata[INDEX_BITS-1:0];
   assign take      = !ent_valid || (rsp_depth_ff < ent_depth);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = {1'b1, rsp_depth_ff, sidx_ff};
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (state_ff == S_UPD) begin
         mem_we = take;
      end
   end

   pdb_depth_unit u_depth (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && (req_cmd == CMD_INSERT) && in_border),
      .world_x (req_world_x),
      .world_y (req_world_y),
      .world_z (req_world_z),
      .cam_x   (cam_x_ff),
      .cam_y   (cam_y_ff),
      .cam_z   (cam_z_ff),
      .done    (du_done),
      .depth   (du_depth)
   );

   pdb_cell_mem #(.DEPTH(NCELLS), .WIDTH(MW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (addr_ff),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         least_ff     <= '1;
         greatest_ff  <= '0;
         width_ff     <= 12'd640;
         height_ff    <= 12'd480;
         subdiv_ff    <= 5'd1;
         cam_x_ff     <= '0;
         cam_y_ff     <= '0;
         cam_z_ff     <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            case (paddr[4:2])
               REG_WIDTH:  width_ff  <= pwdata[11:0];
               REG_HEIGHT: height_ff <= pwdata[11:0];
               REG_SUBDIV: subdiv_ff <= pwdata[4:0];
               REG_CAM_X:  cam_x_ff  <= pwdata[23:0];
               REG_CAM_Y:  cam_y_ff  <= pwdata[23:0];
               REG_CAM_Z:  cam_z_ff  <= pwdata[23:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rsp_depth_ff <= '0;
                  rsp_sidx_ff  <= '0;
                  case (req_cmd)
                     CMD_INSERT: begin
                        addr_ff  <= ins_addr;
                        range_ff <= !cell_ok;
                        sidx_ff  <= INDEX_BITS'(req_source_index);
                        if (in_border) begin
                           state_ff <= S_DEPTH;
                        end else begin
                           rsp_status_ff <= ST_OUTSIDE;
                           rsp_valid_ff  <= 1'b1;
                        end
                     end
                     CMD_READ: begin
                        addr_ff <= rd_addr_cmd;
                        if (read_ok) begin
                           state_ff <= S_RDW;
                        end else begin
                           rsp_status_ff <= ST_RANGE;
                           rsp_valid_ff  <= 1'b1;
                        end
                     end
                     CMD_CLEAR: begin
                        clr_ff     <= '0;
                        clr_rsp_ff <= 1'b1;
                        state_ff   <= S_CLEAR;
                     end
                     default: ;
                  endcase
               end
            end
            S_DEPTH: begin
               if (du_done) begin
                  rsp_depth_ff <= du_depth;
                  if (du_depth < least_ff) least_ff <= du_depth;
                  if (du_depth > greatest_ff) greatest_ff <= du_depth;
                  if (range_ff) begin
                     rsp_status_ff <= ST_RANGE;
                     rsp_valid_ff  <= 1'b1;
                     state_ff      <= S_IDLE;
                  end else begin
                     state_ff <= S_UPD;
                  end
               end
            end
            S_UPD: begin
               // The cell entry is read anew each cycle at addr_ff; nothing wrote it since the insert was accepted.
               rsp_status_ff <= take ? ST_STORED : ST_FARTHER;
               rsp_valid_ff  <= 1'b1;
               state_ff      <= S_IDLE;
            end
            S_RDW: state_ff <= S_RESP;
            S_RESP: begin
               if (ent_valid) begin
                  rsp_status_ff <= ST_HIT;
                  rsp_depth_ff  <= ent_depth;
                  rsp_sidx_ff   <= SIDX_W'(ent_index);
               end else begin
                  rsp_status_ff <= ST_EMPTY;
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == NCELLS - 1) begin
                  state_ff <= S_IDLE;
                  if (clr_rsp_ff) begin
                     rsp_status_ff <= ST_CLEARED;
                     rsp_depth_ff  <= '0;
                     rsp_sidx_ff   <= '0;
                     rsp_valid_ff  <= 1'b1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_WIDTH:  prdata = {20'd0, width_ff};
         REG_HEIGHT: prdata = {20'd0, height_ff};
         REG_SUBDIV: prdata = {27'd0, subdiv_ff};
         REG_CAM_X:  prdata = {8'd0, cam_x_ff};
         REG_CAM_Y:  prdata = {8'd0, cam_y_ff};
         REG_CAM_Z:  prdata = {8'd0, cam_z_ff};
         default:    prdata = '0;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_depth        = rsp_depth_ff;
   assign rsp_stored_index = rsp_sidx_ff;
   assign rsp_min_depth    = least_ff;
   assign rsp_max_depth    = greatest_ff;
endmodule
`default_nettype wire

>>> rtl/pdb_checker.sv
// Port-level checks of the point depth buffer and their binding to the top level.
`default_nettype none
module pdb_checker
   import pdb_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic [1:0]         req_cmd,
   input wire logic               rsp_valid,
   input wire logic [2:0]         rsp_status,
   input wire logic [DEPTH_W-1:0] rsp_depth,
   input wire logic [SIDX_W-1:0]  rsp_stored_index,
   input wire logic [DEPTH_W-1:0] rsp_min_depth,
   input wire logic [DEPTH_W-1:0] rsp_max_depth
);
   // The memory sweep after reset keeps the block busy.
   a_reset_busy: assert property (@(posedge clock) $past(reset) |-> busy)
      else $error("not busy after reset");

   a_accept_acts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd != CMD_IGNORED) |=> (busy || rsp_valid))
      else $error("accepted command neither busy nor answered");

   // A computed depth lies within the tracked extremes.
   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_STORED || rsp_status == ST_FARTHER ||
                     (rsp_status == ST_RANGE && rsp_depth != '0)))
      |-> (rsp_depth >= rsp_min_depth && rsp_depth <= rsp_max_depth))
      else $error("depth outside tracked extremes");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_OUTSIDE || rsp_status == ST_EMPTY ||
                     rsp_status == ST_CLEARED))
      |-> (rsp_depth == '0 && rsp_stored_index == '0))
      else $error("fields not zero on result without data");
endmodule

bind point_depth_buffer pdb_checker u_pdb_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_cmd          (req_cmd),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_depth        (rsp_depth),
   .rsp_stored_index (rsp_stored_index),
   .rsp_min_depth    (rsp_min_depth),
   .rsp_max_depth    (rsp_max_depth)
);
`default_nettype wire
